>>> rtl/drbg_pkg.sv
// Package with shared types, codes and AES tables for the CTR_DRBG block.
package drbg_pkg;

	localparam logic [2:0] REQ_LOAD_ENT = 3'd0;
	localparam logic [2:0] REQ_LOAD_ADD = 3'd1;
	localparam logic [2:0] REQ_INST = 3'd2;
	localparam logic [2:0] REQ_RESEED = 3'd3;
	localparam logic [2:0] REQ_GEN = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_RESEED = 2'd2;
	localparam logic [1:0] ST_ENTROPY = 2'd3;

	localparam logic [0:0] CFG_PRED = 1'd0;
	localparam logic [0:0] CFG_INTERVAL = 1'd1;

	localparam logic [48:0] LIMIT_COUNT = 49'h1_0000_0000_0000;

	// Update source selects for the three-block update.
	localparam logic [1:0] MIX_ZERO = 2'd0;
	localparam logic [1:0] MIX_ENT = 2'd1;
	localparam logic [1:0] MIX_BOTH = 2'd2;

	typedef struct packed {
		logic load_ent;
		logic load_add;
		logic inst;
		logic aes_start;
		logic upd_capture;
		logic [1:0] upd_slot;
		logic upd_apply;
		logic [1:0] mix_sel;
		logic clr_add;
		logic clr_fresh;
		logic set_count_one;
		logic inc_count;
	} dp_cmd_t;

	typedef struct packed {
		logic aes_done;
		logic fresh;
		logic [48:0] reseed_count;
	} dp_stat_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// One AES round on a 128-bit state, byte 0 in the top bits.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] o [16];
		logic [7:0] all;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			b[i] = s[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[4 * c + i] = sbox(b[4 * ((c + i) % 4) + i]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			all = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
			o[4 * c] = t[4 * c] ^ all ^ xtime(t[4 * c] ^ t[4 * c + 1]);
			o[4 * c + 1] = t[4 * c + 1] ^ all ^ xtime(t[4 * c + 1] ^ t[4 * c + 2]);
			o[4 * c + 2] = t[4 * c + 2] ^ all ^ xtime(t[4 * c + 2] ^ t[4 * c + 3]);
			o[4 * c + 3] = t[4 * c + 3] ^ all ^ xtime(t[4 * c + 3] ^ t[4 * c]);
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8 * i -: 8] = last_rnd ? t[i] : o[i];
		end
		return r;
	endfunction

endpackage

>>> rtl/drbg_aes.sv
// Iterative AES-256 encryption core with an on-the-fly key schedule, one round per cycle.
module drbg_aes (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [255:0] key,
	input  logic [127:0] block_in,
	output logic done,
	output logic [127:0] block_out
);

	logic [127:0] state_q;
	logic [255:0] ks_q;
	logic [3:0] rnd_q;
	logic busy_q;
	logic [7:0] rcon_q;
	logic [127:0] rk_next;
	logic [127:0] rnd_out;
	logic [31:0] w0, w1, w2, w3, tmp;
	logic odd;

	// Round r uses key words 4r..4r+3; from round 2 on, ks_q holds words 4r-8..4r-1.
	assign odd = rnd_q[0];
	always_comb begin
		if (!odd) begin
			tmp = drbg_pkg::sub_word({ks_q[23:0], ks_q[31:24]}) ^ {rcon_q, 24'h0};
		end else begin
			tmp = drbg_pkg::sub_word(ks_q[31:0]);
		end
		w0 = ks_q[255:224] ^ tmp;
		w1 = ks_q[223:192] ^ w0;
		w2 = ks_q[191:160] ^ w1;
		w3 = ks_q[159:128] ^ w2;
	end

	always_comb begin
		if (rnd_q == 4'd1) begin
			rk_next = ks_q[127:0];
		end else begin
			rk_next = {w0, w1, w2, w3};
		end
		rnd_out = drbg_pkg::aes_round(state_q, rnd_q == 4'd14) ^ rk_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= 4'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q <= 4'd1;
			end else if (busy_q) begin
				if (rnd_q == 4'd14) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				rnd_q <= rnd_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= block_in ^ key[255:128];
			ks_q <= key;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			state_q <= rnd_out;
			if (rnd_q != 4'd1) begin
				ks_q <= {ks_q[127:0], w0, w1, w2, w3};
				if (odd) begin
					rcon_q <= drbg_pkg::xtime(rcon_q);
				end
			end
		end
	end

	assign block_out = state_q;

endmodule

>>> rtl/drbg_dp.sv
// Datapath: buffers, key and counter registers, reseed counter and the AES core.
module drbg_dp (
	input  logic clk,
	input  logic arst_n,
	input  drbg_pkg::dp_cmd_t cmd,
	input  logic [2:0] word_index,
	input  logic [63:0] data_word,
	output drbg_pkg::dp_stat_t stat,
	output logic [127:0] aes_out
);

	logic [63:0] ent_q [6];
	logic [63:0] add_q [6];
	logic [255:0] key_q;
	logic [127:0] v_q;
	logic [48:0] count_q;
	logic fresh_q;
	logic [255:0] upd_q;
	logic [383:0] mix;
	logic [127:0] v_inc;
	logic aes_done;

	assign v_inc = v_q + 128'd1;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			unique case (cmd.mix_sel)
				drbg_pkg::MIX_ENT: mix[383 - 64 * i -: 64] = ent_q[i];
				drbg_pkg::MIX_BOTH: mix[383 - 64 * i -: 64] = ent_q[i] ^ add_q[i];
				default: mix[383 - 64 * i -: 64] = 64'd0;
			endcase
		end
	end

	drbg_aes u_aes (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.aes_start),
		.key(key_q),
		.block_in(v_inc),
		.done(aes_done),
		.block_out(aes_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				ent_q[i] <= 64'd0;
				add_q[i] <= 64'd0;
			end
			key_q <= '0;
			v_q <= '0;
			count_q <= '0;
			fresh_q <= 1'b0;
		end else begin
			if (cmd.load_ent && word_index < 3'd6) begin
				ent_q[word_index] <= data_word;
				fresh_q <= 1'b1;
			end
			if (cmd.load_add && word_index < 3'd6) begin
				add_q[word_index] <= data_word;
			end
			if (cmd.aes_start) begin
				v_q <= v_inc;
			end
			if (cmd.inst) begin
				key_q <= mix[383:128];
				v_q <= mix[127:0];
			end
			if (cmd.upd_apply) begin
				key_q <= upd_q ^ mix[383:128];
				v_q <= aes_out ^ mix[127:0];
			end
			if (cmd.clr_add) begin
				for (int i = 0; i < 6; i++) begin
					add_q[i] <= 64'd0;
				end
			end
			if (cmd.clr_fresh) begin
				fresh_q <= 1'b0;
			end
			if (cmd.set_count_one) begin
				count_q <= 49'd1;
			end else if (cmd.inc_count) begin
				count_q <= count_q + 49'd1;
			end
		end
	end

	// The third update block is applied straight from the core output.
	always_ff @(posedge clk) begin
		if (cmd.upd_capture) begin
			unique case (cmd.upd_slot)
				2'd0: upd_q[255:128] <= aes_out;
				2'd1: upd_q[127:0] <= aes_out;
				default: ;
			endcase
		end
	end

	assign stat.aes_done = aes_done;
	assign stat.fresh = fresh_q;
	assign stat.reseed_count = count_q;

endmodule

>>> rtl/drbg_ctrl.sv
// Controller state machine that sequences requests, updates and output words.
module drbg_ctrl #(
	parameter int MAX_REQUEST_BYTES = 512
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] req_type,
	input  logic [9:0] byte_count,
	input  logic pred_res,
	input  logic [48:0] interval,
	input  drbg_pkg::dp_stat_t stat,
	input  logic [127:0] aes_out,
	output drbg_pkg::dp_cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [63:0] random_word,
	output logic [3:0] byte_valid_count,
	output logic last
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_GEN = 3'd3;
	localparam logic [2:0] S_HI = 3'd4;
	localparam logic [2:0] S_LO = 3'd5;
	localparam logic [2:0] S_RESP = 3'd6;

	logic [2:0] state_q;
	logic [1:0] blk_q;
	logic waiting_q;
	logic [1:0] mix_q;
	logic [1:0] after_q;
	logic [9:0] rem_q;
	logic [63:0] lo_q;
	logic accept;
	logic [3:0] nvalid;
	logic [63:0] mask;
	logic [63:0] word_sel;

	localparam logic [1:0] AFT_RESP = 2'd0;
	localparam logic [1:0] AFT_CHECK = 2'd1;
	localparam logic [1:0] AFT_FINISH = 2'd2;

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign accept = in_valid && in_ready;

	assign nvalid = (rem_q > 10'd8) ? 4'd8 : rem_q[3:0];
	always_comb begin
		mask = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < nvalid) begin
				mask[63 - 8 * i -: 8] = 8'hff;
			end
		end
		word_sel = (state_q == S_HI) ? aes_out[127:64] : lo_q;
	end

	always_comb begin
		cmd = '0;
		cmd.mix_sel = mix_q;
		if (accept) begin
			cmd.load_ent = req_type == drbg_pkg::REQ_LOAD_ENT;
			cmd.load_add = req_type == drbg_pkg::REQ_LOAD_ADD;
			if (req_type == drbg_pkg::REQ_INST) begin
				cmd.inst = 1'b1;
				cmd.mix_sel = drbg_pkg::MIX_BOTH;
				cmd.clr_add = 1'b1;
				cmd.clr_fresh = 1'b1;
				cmd.set_count_one = 1'b1;
			end
		end
		if (state_q == S_UPD) begin
			cmd.aes_start = !waiting_q;
			cmd.upd_capture = stat.aes_done;
			cmd.upd_slot = blk_q;
			if (stat.aes_done && blk_q == 2'd2) begin
				cmd.upd_apply = 1'b1;
				unique case (after_q)
					AFT_RESP: begin
						cmd.clr_add = 1'b1;
						cmd.clr_fresh = 1'b1;
						cmd.set_count_one = 1'b1;
					end
					AFT_CHECK: begin
						cmd.clr_fresh = 1'b1;
						cmd.set_count_one = 1'b1;
					end
					default: cmd.inc_count = 1'b1;
				endcase
			end
		end
		if (state_q == S_GEN) begin
			cmd.aes_start = !waiting_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			waiting_q <= 1'b0;
			blk_q <= 2'd0;
			mix_q <= drbg_pkg::MIX_ZERO;
			after_q <= AFT_RESP;
			rem_q <= '0;
			lo_q <= '0;
			status <= drbg_pkg::ST_OK;
			random_word <= '0;
			byte_valid_count <= '0;
			last <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_HI && state_q != S_LO) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rem_q <= byte_count;
						if (req_type == drbg_pkg::REQ_RESEED) begin
							state_q <= S_UPD;
							mix_q <= drbg_pkg::MIX_BOTH;
							after_q <= AFT_RESP;
							blk_q <= 2'd0;
						end else if (req_type == drbg_pkg::REQ_GEN) begin
							if (byte_count > 10'(MAX_REQUEST_BYTES)) begin
								out_valid <= 1'b1;
								status <= drbg_pkg::ST_BAD_LEN;
								random_word <= '0;
								byte_valid_count <= '0;
								last <= 1'b1;
							end else if (pred_res && stat.reseed_count > interval) begin
								if (!stat.fresh) begin
									out_valid <= 1'b1;
									status <= drbg_pkg::ST_ENTROPY;
									random_word <= '0;
									byte_valid_count <= '0;
									last <= 1'b1;
								end else begin
									state_q <= S_UPD;
									mix_q <= drbg_pkg::MIX_ENT;
									after_q <= AFT_CHECK;
									blk_q <= 2'd0;
								end
							end else begin
								state_q <= S_CHECK;
							end
						end else begin
							out_valid <= 1'b1;
							status <= drbg_pkg::ST_OK;
							random_word <= '0;
							byte_valid_count <= '0;
							last <= 1'b1;
						end
					end
				end
				S_UPD: begin
					if (!waiting_q) begin
						waiting_q <= 1'b1;
					end else if (stat.aes_done) begin
						waiting_q <= 1'b0;
						if (blk_q == 2'd2) begin
							blk_q <= 2'd0;
							unique case (after_q)
								AFT_CHECK: state_q <= S_CHECK;
								AFT_FINISH: state_q <= S_IDLE;
								default: state_q <= S_RESP;
							endcase
						end else begin
							blk_q <= blk_q + 2'd1;
						end
					end
				end
				S_CHECK: begin
					if (stat.reseed_count > drbg_pkg::LIMIT_COUNT) begin
						status <= drbg_pkg::ST_RESEED;
						random_word <= '0;
						byte_valid_count <= '0;
						last <= 1'b1;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (rem_q == 10'd0) begin
						status <= drbg_pkg::ST_OK;
						random_word <= '0;
						byte_valid_count <= '0;
						last <= 1'b1;
						out_valid <= 1'b1;
						state_q <= S_UPD;
						mix_q <= drbg_pkg::MIX_ZERO;
						after_q <= AFT_FINISH;
					end else begin
						state_q <= S_GEN;
					end
				end
				S_GEN: begin
					if (!waiting_q) begin
						waiting_q <= 1'b1;
					end else if (stat.aes_done) begin
						waiting_q <= 1'b0;
						lo_q <= aes_out[63:0];
						state_q <= S_HI;
					end
				end
				S_HI, S_LO: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status <= drbg_pkg::ST_OK;
						random_word <= word_sel & mask;
						byte_valid_count <= nvalid;
						last <= rem_q <= 10'd8;
						if (rem_q <= 10'd8) begin
							rem_q <= '0;
							state_q <= S_UPD;
							mix_q <= drbg_pkg::MIX_ZERO;
							after_q <= AFT_FINISH;
						end else begin
							rem_q <= rem_q - 10'd8;
							state_q <= (state_q == S_HI) ? S_LO : S_GEN;
						end
					end
				end
				S_RESP: begin
					out_valid <= 1'b1;
					status <= drbg_pkg::ST_OK;
					random_word <= '0;
					byte_valid_count <= '0;
					last <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/aes256_ctr_drbg.sv
// Top level of the AES-256 CTR_DRBG without a derivation function.
// One request is handled at a time. Loads, instantiate and rejected generates answer
// without running the AES core; a reseed takes three AES-256 blocks from the single
// iterative round unit; a generate of n bytes takes ceil(n/16) blocks
// plus a three-block update, and three more blocks when a prediction reseed runs, so a
// 512-byte request without a prediction reseed takes 35 blocks and yields 64 output words.
module aes256_ctr_drbg #(
	parameter int MAX_REQUEST_BYTES = 512
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] req_type,
	input  logic [2:0] word_index,
	input  logic [63:0] data_word,
	input  logic [9:0] byte_count,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [63:0] random_word,
	output logic [3:0] byte_valid_count,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [48:0] cfg_data
);

	drbg_pkg::dp_cmd_t cmd;
	drbg_pkg::dp_stat_t stat;
	logic [127:0] aes_out;
	logic pred_q;
	logic [48:0] interval_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= 1'b0;
			interval_q <= drbg_pkg::LIMIT_COUNT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				drbg_pkg::CFG_PRED: pred_q <= cfg_data[0];
				default: interval_q <= cfg_data;
			endcase
		end
	end

	drbg_ctrl #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.byte_count(byte_count),
		.pred_res(pred_q),
		.interval(interval_q),
		.stat(stat),
		.aes_out(aes_out),
		.cmd(cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.random_word(random_word),
		.byte_valid_count(byte_valid_count),
		.last(last)
	);

	drbg_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.word_index(word_index),
		.data_word(data_word),
		.stat(stat),
		.aes_out(aes_out)
	);

endmodule

>>> rtl/drbg_checker.sv
// Port-level checker for the CTR_DRBG block and its bind statement.
module drbg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [3:0] byte_valid_count,
	input logic last,
	input logic [63:0] random_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_word))
		else $error("result changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != drbg_pkg::ST_OK |-> last && byte_valid_count == 4'd0)
		else $error("error transaction not final");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_valid_count <= 4'd8)
		else $error("byte count out of range");

	a_partial: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid_count != 4'd8 |-> last)
		else $error("partial word not final");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("transaction accepted while a result is pending");

endmodule

bind aes256_ctr_drbg drbg_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.byte_valid_count(byte_valid_count),
	.last(last),
	.random_word(random_word)
);
